/* rtl/core/plsc_pkg.sv */
package plsc_pkg;

  // widths fixed by the packet format
  localparam int unsigned WORD_W = 32;
  localparam int unsigned SRC_W  = 8;
  localparam int unsigned CMD_W  = 2;

  // defaults handed to the top level
  localparam int unsigned NUM_SOURCES_DEF = 256;
  localparam logic [WORD_W-1:0] PREAMBLE_RESET = 32'h0000_DADA;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PACKET = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // one source's statistics as held in the table
  typedef struct packed {
    logic [WORD_W-1:0] last_seq;
    logic [WORD_W-1:0] recv;
    logic [WORD_W-1:0] drop;
  } entry_t;

  // write port control into the statistics table
  typedef struct packed {
    logic data_en;
    logic valid_en;
    logic valid_bit;
  } tbl_wr_t;

endpackage

/* rtl/core/per_source_packet_loss_counter.sv */
// Per-source packet loss counter.
//
// Requests enter on start with cmd, preamble_word, sequence_req and source_id
// and are taken at a clock edge where start is high and busy is low. A packet
// request in range whose preamble equals the programmed marker updates its
// received and dropped counts and last sequence; any other preamble bumps the
// foreign count. Read requests return a source's statistics, clear requests
// empty the whole table. Each request gives one result, shown on the result
// ports for a single cycle with done high; the receiver cannot stall it.
//
// Packet and read requests: the table is read at the accepting edge, and the
// result and write-back are registered in the lookup state that follows, so
// done rises in the cycle in which busy is low again; the lookup state waits
// for the registered read of the table memory. Clear requests answer on the
// next cycle, then the valid store is swept one entry a cycle over all
// NUM_SOURCES entries with busy high. The same sweep runs after reset, so the
// block takes its first request only once that sweep is through after rst
// falls. The marker register (cfg_we / cfg_wdata) resets to 0xDADA and may be
// written at any time, taking effect on the next request.
module per_source_packet_loss_counter #(
  parameter int unsigned NUM_SOURCES = plsc_pkg::NUM_SOURCES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [plsc_pkg::WORD_W-1:0]     cfg_wdata,
  input  logic                            start,
  output logic                            busy,
  input  logic [plsc_pkg::CMD_W-1:0]      cmd,
  input  logic [plsc_pkg::WORD_W-1:0]     preamble_word,
  input  logic [plsc_pkg::WORD_W-1:0]     sequence_req,
  input  logic [plsc_pkg::SRC_W-1:0]      source_id,
  output logic                            done,
  output logic                            matched,
  output logic [plsc_pkg::WORD_W-1:0]     received_count,
  output logic [plsc_pkg::WORD_W-1:0]     dropped_count,
  output logic [plsc_pkg::WORD_W-1:0]     last_sequence,
  output logic [plsc_pkg::WORD_W-1:0]     foreign_count
);
  import plsc_pkg::*;

  localparam int unsigned IDX_W = $clog2(NUM_SOURCES);
  localparam int unsigned ID_EXT_W = ((IDX_W > SRC_W) ? IDX_W : SRC_W) + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SOURCES - 1);

  typedef enum logic [2:0] {
    S_SWEEP  = 3'b001,
    S_IDLE   = 3'b010,
    S_LOOKUP = 3'b100
  } state_t;

  state_t            state;
  logic [IDX_W-1:0]  sweep_cnt;
  logic [WORD_W-1:0] preamble;
  logic [WORD_W-1:0] foreign;
  logic [WORD_W-1:0] foreign_next;

  logic [CMD_W-1:0]  req_cmd;
  logic [WORD_W-1:0] req_pre;
  logic [WORD_W-1:0] req_seq;
  logic [IDX_W-1:0]  req_idx;
  logic              req_in_range;

  logic [ID_EXT_W-1:0] id_ext;
  logic [IDX_W-1:0]    in_idx;
  logic                in_range;
  logic                accept;

  entry_t  rd_entry;
  logic    rd_valid;
  entry_t  cur_entry;
  entry_t  upd_entry;
  entry_t  res_entry;
  tbl_wr_t wr_ctl;
  logic [IDX_W-1:0] wr_idx;
  logic    do_update;
  logic    do_foreign;

  // request decode
  assign id_ext   = ID_EXT_W'(source_id);
  assign in_idx   = id_ext[IDX_W-1:0];
  assign in_range = id_ext < ID_EXT_W'(NUM_SOURCES);
  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;

  // lookup stage: stored entry, masked when empty or out of range
  always_comb begin
    cur_entry  = (req_in_range && rd_valid) ? rd_entry : '0;
    do_update  = (req_cmd == CMD_PACKET) && req_in_range && (req_pre == preamble);
    do_foreign = (req_cmd == CMD_PACKET) && req_in_range && (req_pre != preamble);
    res_entry  = do_update ? upd_entry : cur_entry;
    foreign_next = foreign + WORD_W'(do_foreign);
  end

  plsc_update u_update (
    .cur (cur_entry),
    .seq (req_seq),
    .upd (upd_entry)
  );

  // table write: sweep clears valid bits, lookup writes back the update
  always_comb begin
    wr_ctl.data_en   = (state == S_LOOKUP) && do_update;
    wr_ctl.valid_en  = (state == S_SWEEP) || ((state == S_LOOKUP) && do_update);
    wr_ctl.valid_bit = (state != S_SWEEP);
    wr_idx           = (state == S_SWEEP) ? sweep_cnt : req_idx;
  end

  plsc_stats_mem #(
    .DEPTH (NUM_SOURCES),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk      (clk),
    .rd_en    (accept),
    .rd_idx   (in_idx),
    .rd_entry (rd_entry),
    .rd_valid (rd_valid),
    .wr_ctl   (wr_ctl),
    .wr_idx   (wr_idx),
    .wr_entry (upd_entry)
  );

  // control state, marker register and foreign counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      sweep_cnt <= '0;
      preamble  <= PREAMBLE_RESET;
      foreign   <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        preamble <= cfg_wdata;
      end
      case (state)
        S_SWEEP: begin
          sweep_cnt <= sweep_cnt + IDX_W'(1);
          if (sweep_cnt == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            if (cmd == CMD_CLEAR) begin
              foreign   <= '0;
              done      <= 1'b1;
              sweep_cnt <= '0;
              state     <= S_SWEEP;
            end else begin
              state <= S_LOOKUP;
            end
          end
        end
        S_LOOKUP: begin
          foreign <= foreign_next;
          done    <= 1'b1;
          state   <= S_IDLE;
        end
        default: begin
          state <= S_SWEEP;
        end
      endcase
    end
  end

  // captured request
  always_ff @(posedge clk) begin
    if (accept) begin
      req_cmd      <= cmd;
      req_pre      <= preamble_word;
      req_seq      <= sequence_req;
      req_idx      <= in_idx;
      req_in_range <= in_range;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (accept && (cmd == CMD_CLEAR)) begin
      matched        <= 1'b0;
      received_count <= '0;
      dropped_count  <= '0;
      last_sequence  <= '0;
      foreign_count  <= '0;
    end else if (state == S_LOOKUP) begin
      matched        <= do_update;
      received_count <= res_entry.recv;
      dropped_count  <= res_entry.drop;
      last_sequence  <= res_entry.last_seq;
      foreign_count  <= foreign_next;
    end
  end

  // packet and read requests answer after the table read and the lookup state
  a_lookup_latency: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd != CMD_CLEAR)) |=> ##1 done)
    else $error("lookup result missing");

  // clear answers with empty statistics and starts the sweep
  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == CMD_CLEAR)) |=>
      (done && (foreign_count == '0) && (received_count == '0) && (state == S_SWEEP)))
    else $error("clear result wrong");

  // a counted packet only comes out of the lookup stage
  a_matched_src: assert property (@(posedge clk) disable iff (rst)
    (done && matched) |-> ($past(state) == S_LOOKUP))
    else $error("matched result outside lookup");

  // table data is written only by a counted packet, never during the sweep
  a_write_guard: assert property (@(posedge clk) disable iff (rst)
    wr_ctl.data_en |-> ((state == S_LOOKUP) && req_in_range))
    else $error("stray table write");

endmodule

/* rtl/core/plsc_stats_mem.sv */
module plsc_stats_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned IDX_W = 8
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [IDX_W-1:0]    rd_idx,
  output plsc_pkg::entry_t    rd_entry,
  output logic                rd_valid,
  input  plsc_pkg::tbl_wr_t   wr_ctl,
  input  logic [IDX_W-1:0]    wr_idx,
  input  plsc_pkg::entry_t    wr_entry
);
  import plsc_pkg::*;

  // statistics store, contents undefined until written
  entry_t data_mem [DEPTH];
  // entry valid store, cleared by the sweep in the control logic
  logic   vld_mem  [DEPTH];

  // data store, one read and one write port
  always_ff @(posedge clk) begin
    if (wr_ctl.data_en) begin
      data_mem[wr_idx] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry <= data_mem[rd_idx];
    end
  end

  // valid store, same addressing
  always_ff @(posedge clk) begin
    if (wr_ctl.valid_en) begin
      vld_mem[wr_idx] <= wr_ctl.valid_bit;
    end
    if (rd_en) begin
      rd_valid <= vld_mem[rd_idx];
    end
  end

endmodule

/* rtl/core/plsc_update.sv */
module plsc_update (
  input  plsc_pkg::entry_t                  cur,
  input  logic [plsc_pkg::WORD_W-1:0]       seq,
  output plsc_pkg::entry_t                  upd
);
  import plsc_pkg::*;

  logic [WORD_W-1:0] gap;

  // modular gap since the last stored sequence, none if nothing stored
  always_comb begin
    gap = (cur.last_seq != '0) ? (seq - cur.last_seq - WORD_W'(1)) : '0;
  end

  // counters wrap at word width
  always_comb begin
    upd.recv     = cur.recv + WORD_W'(1);
    upd.drop     = cur.drop + gap;
    upd.last_seq = seq;
  end

endmodule
